>>> hw/rtl/gpfp_pkg.sv
// ----------------------------------------------------------------------------
// gpfp_pkg
// Shared widths, state and command types for the grid partition factor pair
// block.
// ----------------------------------------------------------------------------
package gpfp_pkg;

  // Width of a partition count and of each grid dimension
  localparam int COUNT_WIDTH = 16;
  // Width of an integer square root of a count
  localparam int ROOT_WIDTH  = (COUNT_WIDTH + 1) / 2;
  // Step counter covers the longer of the sqrt and divide sequences
  localparam int STEP_WIDTH  = $clog2(COUNT_WIDTH);
  // Stream bus widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((COUNT_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COUNT_WIDTH + 7) / 8) * 8;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_EVAL,
    ST_CAND,
    ST_DIV,
    ST_TEST,
    ST_RESULT
  } gpfp_state_t;

  // Which pair the result register takes
  typedef enum logic [1:0] {
    RES_SQUARE,
    RES_PRIME,
    RES_DIVISOR
  } gpfp_res_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic          load;       // capture count, start square root
    logic          sqrt_step;  // one root digit
    logic          a_load;     // first candidate divisor = root
    logic          a_dec;      // next lower candidate
    logic          div_start;  // start n / a
    logic          div_step;   // one quotient bit
    logic          sel_load;   // latch result selection
    gpfp_res_sel_t sel;
    logic          out_load;   // write result register
  } gpfp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic step_last;     // step counter at zero
    logic sq_exact;      // square root remainder is zero
    logic a_le_one;      // candidate divisor at or below one
    logic div_rem_zero;  // divide remainder is zero
  } gpfp_sts_t;

endpackage

>>> hw/rtl/gpfp_dp.sv
// ----------------------------------------------------------------------------
// gpfp_dp
// Datapath: digit-by-digit square root, bit-serial restoring divider,
// candidate divisor register and result register.
// ----------------------------------------------------------------------------
module gpfp_dp (
  input  logic                          clk,
  input  logic [gpfp_pkg::COUNT_WIDTH-1:0] in_count,
  input  gpfp_pkg::gpfp_cmd_t           cmd,
  output gpfp_pkg::gpfp_sts_t           sts,
  output logic [gpfp_pkg::COUNT_WIDTH-1:0] rows,
  output logic [gpfp_pkg::COUNT_WIDTH-1:0] cols
);
  import gpfp_pkg::*;

  localparam int W  = COUNT_WIDTH;
  localparam int RW = ROOT_WIDTH;

  logic [W-1:0]      n_r;
  logic [2*RW-1:0]   sq_src_r;
  logic [RW-1:0]     sq_root_r;
  logic [RW+1:0]     sq_rem_r;
  logic [RW-1:0]     a_r;
  logic [RW-1:0]     dv_rem_r;
  logic [W-1:0]      dv_quo_r;
  logic [STEP_WIDTH-1:0] cnt_r;
  gpfp_res_sel_t     sel_r;
  logic [W-1:0]      rows_r;
  logic [W-1:0]      cols_r;

  logic [RW+3:0]     sq_tmp;
  logic [RW+3:0]     sq_trial;
  logic [RW+3:0]     sq_diff;
  logic              sq_ge;
  logic [RW:0]       dv_tmp;
  logic [RW:0]       dv_diff;
  logic              dv_ge;
  logic [W-1:0]      res_rows;
  logic [W-1:0]      res_cols;

  // Square root digit: bring down two bits, try (root << 2) | 1
  always_comb begin
    sq_tmp   = {sq_rem_r, sq_src_r[2*RW-1 -: 2]};
    sq_trial = {2'b00, sq_root_r, 2'b01};
    sq_diff  = sq_tmp - sq_trial;
    sq_ge    = (sq_tmp >= sq_trial);
  end

  // Restoring divide: shift in next dividend bit, compare with divisor
  always_comb begin
    dv_tmp  = {dv_rem_r, dv_quo_r[W-1]};
    dv_diff = dv_tmp - {1'b0, a_r};
    dv_ge   = (dv_tmp >= {1'b0, a_r});
  end

  // Result pair selection
  always_comb begin
    case (sel_r)
      RES_SQUARE: begin
        res_rows = W'(sq_root_r);
        res_cols = W'(sq_root_r);
      end
      RES_PRIME: begin
        res_rows = W'(1);
        res_cols = n_r;
      end
      RES_DIVISOR: begin
        res_rows = dv_quo_r;
        res_cols = W'(a_r);
      end
      default: begin
        res_rows = dv_quo_r;
        res_cols = W'(a_r);
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r       <= in_count;
      sq_src_r  <= (2*RW)'(in_count);
      sq_root_r <= '0;
      sq_rem_r  <= '0;
    end else if (cmd.sqrt_step) begin
      sq_src_r  <= sq_src_r << 2;
      sq_rem_r  <= sq_ge ? sq_diff[RW+1:0] : sq_tmp[RW+1:0];
      sq_root_r <= RW'({sq_root_r, sq_ge});
    end

    if (cmd.a_load) begin
      a_r <= sq_root_r;
    end else if (cmd.a_dec) begin
      a_r <= a_r - RW'(1);
    end

    if (cmd.div_start) begin
      dv_rem_r <= '0;
      dv_quo_r <= n_r;
    end else if (cmd.div_step) begin
      dv_rem_r <= dv_ge ? dv_diff[RW-1:0] : dv_tmp[RW-1:0];
      dv_quo_r <= {dv_quo_r[W-2:0], dv_ge};
    end

    // Step counter shared by both sequences
    if (cmd.load) begin
      cnt_r <= STEP_WIDTH'(RW - 1);
    end else if (cmd.div_start) begin
      cnt_r <= STEP_WIDTH'(W - 1);
    end else if (cmd.sqrt_step || cmd.div_step) begin
      cnt_r <= cnt_r - STEP_WIDTH'(1);
    end

    if (cmd.sel_load) begin
      sel_r <= cmd.sel;
    end

    if (cmd.out_load) begin
      rows_r <= res_rows;
      cols_r <= res_cols;
    end
  end

  assign sts.step_last    = (cnt_r == '0);
  assign sts.sq_exact     = (sq_rem_r == '0);
  assign sts.a_le_one     = (a_r <= RW'(1));
  assign sts.div_rem_zero = (dv_rem_r == '0);

  assign rows = rows_r;
  assign cols = cols_r;

endmodule

>>> hw/rtl/gpfp_ctrl.sv
// ----------------------------------------------------------------------------
// gpfp_ctrl
// Controller: sequences square root, divisor search and result hand-off,
// and owns the stream handshakes.
// ----------------------------------------------------------------------------
module gpfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  gpfp_pkg::gpfp_sts_t sts,
  output gpfp_pkg::gpfp_cmd_t cmd
);
  import gpfp_pkg::*;

  gpfp_state_t state_r;
  gpfp_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = RES_SQUARE;
    in_tready = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = ST_EVAL;
        end
      end
      // Exact square (count of one included) ends here
      ST_EVAL: begin
        if (sts.sq_exact) begin
          cmd.sel_load = 1'b1;
          cmd.sel      = RES_SQUARE;
          state_nxt    = ST_RESULT;
        end else begin
          cmd.a_load = 1'b1;
          state_nxt  = ST_CAND;
        end
      end
      // No divisor above one left: prime
      ST_CAND: begin
        if (sts.a_le_one) begin
          cmd.sel_load = 1'b1;
          cmd.sel      = RES_PRIME;
          state_nxt    = ST_RESULT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.div_rem_zero) begin
          cmd.sel_load = 1'b1;
          cmd.sel      = RES_DIVISOR;
          state_nxt    = ST_RESULT;
        end else begin
          cmd.a_dec = 1'b1;
          state_nxt = ST_CAND;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hw/rtl/grid_partition_factor_pair_core.sv
// ----------------------------------------------------------------------------
// grid_partition_factor_pair_core
// Splits a partition count into the closest rows-by-columns factor pair.
// ----------------------------------------------------------------------------
// One count in, one (rows, cols) pair out. A perfect square (and a count of
// one) gives root by root; zero gives 0 by 0. Otherwise divisors are tried
// from floor(sqrt(n)) downward and the first one a gives rows = n / a,
// cols = a; a prime gives 1 by n. Items are handled one at a time: the
// square root yields one root bit a cycle, and each candidate divisor
// is tried by a bit-serial restoring divide followed by a remainder test
// and a decrement. The result sits in an output register, so the next
// count is taken while a result still waits.
// ----------------------------------------------------------------------------
module grid_partition_factor_pair_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // [15:0] partition_count
  input  logic [gpfp_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] grid_rows, [31:16] grid_cols
  output logic [gpfp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready
);
  import gpfp_pkg::*;

  gpfp_cmd_t              cmd;
  gpfp_sts_t              sts;
  logic [COUNT_WIDTH-1:0] grid_rows;
  logic [COUNT_WIDTH-1:0] grid_cols;

  // Sequencer
  gpfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic
  gpfp_dp u_dp (
    .clk      (clk),
    .in_count (in_tdata[COUNT_WIDTH-1:0]),
    .cmd      (cmd),
    .sts      (sts),
    .rows     (grid_rows),
    .cols     (grid_cols)
  );

  assign out_tdata = OUT_TDATA_W'({grid_cols, grid_rows});

  // Block is busy right after taking a count
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready
  ) else $error("input accepted again while computing");

  // A divisor result only follows an exact division
  a_divisor_exact: assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd.sel_load && cmd.sel == RES_DIVISOR) |-> sts.div_rem_zero
  ) else $error("divisor chosen with nonzero remainder");

  // Result write always raises the output valid
  a_out_load_valid: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid
  ) else $error("result written but not presented");

  // At most one datapath sequencing command per cycle
  a_cmd_exclusive: assert property (
    @(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.sqrt_step, cmd.div_start, cmd.div_step, cmd.a_dec,
              cmd.out_load})
  ) else $error("conflicting datapath commands");

endmodule
